>>> sv/ata_pkg.sv
package ata_pkg;

	// Default widths
	localparam int COORD_WIDTH_DEF = 16;
	localparam int ANGLE_FRAC_DEF  = 13;

	// Ratio format: Q1.15, magnitude up to 2^15
	localparam int RATIO_FRAC = 15;
	localparam int QUOT_W     = RATIO_FRAC + 1;

	// Divider split: quotient bits resolved per register stage
	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = QUOT_W / DIV_STEPS;

	// Polynomial coefficients, Q0.15
	localparam logic [15:0]        COEF_N1 = 16'd31863;
	localparam logic signed [14:0] COEF_N2 = -15'sd6290;

	// p = N1*2^15 + N2*z2 stays positive and below 2^30
	localparam int P_W = 30;
	localparam int M_W = QUOT_W + P_W;

	// pi with 61 fraction bits
	localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;

	// Quadrant and sign flags that travel with each item
	typedef struct packed {
		logic x_zero;
		logic x_neg;
		logic y_zero;
		logic y_neg;
		logic swap;
		logic z_neg;
	} ata_quad_t;

	// Round pi to the given number of fraction bits
	function automatic logic [63:0] pi_fixed(input int frac);
		return (PI_Q61 + (64'd1 << (60 - frac))) >> (61 - frac);
	endfunction

	// Round pi/2 to the given number of fraction bits
	function automatic logic [63:0] half_pi_fixed(input int frac);
		return (PI_Q61 + (64'd1 << (61 - frac))) >> (62 - frac);
	endfunction

endpackage

>>> sv/ata_front.sv
module ata_front #(
	parameter int COORD_WIDTH = ata_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [COORD_WIDTH-1:0] x_value,
	input  logic signed [COORD_WIDTH-1:0] y_value,
	input  logic                          in_valid,
	output logic                          in_ready,
	output logic [COORD_WIDTH-1:0]        num,
	output logic [COORD_WIDTH-1:0]        den,
	output ata_pkg::ata_quad_t            quad,
	output logic                          out_valid,
	input  logic                          out_ready
);

	logic [COORD_WIDTH-1:0] ax, ay;
	ata_pkg::ata_quad_t     quad_nx;
	logic                   vld_s1;
	logic [COORD_WIDTH-1:0] num_s1, den_s1;
	ata_pkg::ata_quad_t     quad_s1;

	// Take magnitudes, pick the smaller one as numerator
	always_comb begin
		ax = x_value[COORD_WIDTH-1] ? (~x_value + 1'b1) : x_value;
		ay = y_value[COORD_WIDTH-1] ? (~y_value + 1'b1) : y_value;
		quad_nx.x_zero = (x_value == '0);
		quad_nx.x_neg  = x_value[COORD_WIDTH-1];
		quad_nx.y_zero = (y_value == '0);
		quad_nx.y_neg  = y_value[COORD_WIDTH-1];
		quad_nx.swap   = (ax < ay);
		quad_nx.z_neg  = x_value[COORD_WIDTH-1] ^ y_value[COORD_WIDTH-1];
	end

	assign in_ready = !vld_s1 || out_ready;

	// Hold valid until the next stage takes the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	// Load payload on accept
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			num_s1  <= quad_nx.swap ? ax : ay;
			den_s1  <= quad_nx.swap ? ay : ax;
			quad_s1 <= quad_nx;
		end
	end

	assign num       = num_s1;
	assign den       = den_s1;
	assign quad      = quad_s1;
	assign out_valid = vld_s1;

endmodule

>>> sv/ata_div.sv
module ata_div #(
	parameter int COORD_WIDTH = ata_pkg::COORD_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [COORD_WIDTH-1:0]         num,
	input  logic [COORD_WIDTH-1:0]         den,
	input  ata_pkg::ata_quad_t             quad_in,
	input  logic                           in_valid,
	output logic                           in_ready,
	output logic [ata_pkg::QUOT_W-1:0]     zmag,
	output ata_pkg::ata_quad_t             quad_out,
	output logic                           out_valid,
	input  logic                           out_ready
);

	localparam int REM_W  = COORD_WIDTH + 1;
	localparam int NSTAGE = ata_pkg::DIV_STAGES;
	localparam int QW     = ata_pkg::QUOT_W;

	// Stage inputs: index 0 is the module input, index k+1 is register stage k
	logic [REM_W-1:0]       rem_at  [NSTAGE+1];
	logic [COORD_WIDTH-1:0] den_at  [NSTAGE+1];
	logic [QW-1:0]          quo_at  [NSTAGE+1];
	ata_pkg::ata_quad_t     quad_at [NSTAGE+1];
	logic                   vld_at  [NSTAGE+1];
	logic                   rdy_at  [NSTAGE+1];

	// Stage registers
	logic [REM_W-1:0]       rem_s   [NSTAGE];
	logic [COORD_WIDTH-1:0] den_s   [NSTAGE];
	logic [QW-1:0]          quo_s   [NSTAGE];
	ata_pkg::ata_quad_t     quad_s  [NSTAGE];
	logic                   vld_s   [NSTAGE];

	assign rem_at[0]  = {1'b0, num};
	assign den_at[0]  = den;
	assign quo_at[0]  = '0;
	assign quad_at[0] = quad_in;
	assign vld_at[0]  = in_valid;
	assign in_ready   = rdy_at[0];
	assign rdy_at[NSTAGE] = out_ready;

	for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
		logic [REM_W-1:0] rem_nx;
		logic [QW-1:0]    quo_nx;

		// Resolve a group of quotient bits by compare and subtract
		always_comb begin
			logic [REM_W-1:0] r;
			logic [QW-1:0]    q;
			logic             ge;
			r = rem_at[k];
			q = quo_at[k];
			for (int i = 0; i < ata_pkg::DIV_STEPS; i++) begin
				ge = (r >= {1'b0, den_at[k]});
				if (ge) begin
					r = r - {1'b0, den_at[k]};
				end
				q = {q[QW-2:0], ge};
				r = {r[REM_W-2:0], 1'b0};
			end
			rem_nx = r;
			quo_nx = q;
		end

		assign rdy_at[k] = !vld_s[k] || rdy_at[k+1];

		// Advance valid when the stage is free or drains
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy_at[k]) begin
				vld_s[k] <= vld_at[k];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy_at[k] && vld_at[k]) begin
				rem_s[k]  <= rem_nx;
				den_s[k]  <= den_at[k];
				quo_s[k]  <= quo_nx;
				quad_s[k] <= quad_at[k];
			end
		end

		assign rem_at[k+1]  = rem_s[k];
		assign den_at[k+1]  = den_s[k];
		assign quo_at[k+1]  = quo_s[k];
		assign quad_at[k+1] = quad_s[k];
		assign vld_at[k+1]  = vld_s[k];
	end

	assign zmag      = quo_at[NSTAGE];
	assign quad_out  = quad_at[NSTAGE];
	assign out_valid = vld_at[NSTAGE];

endmodule

>>> sv/ata_poly.sv
module ata_poly #(
	parameter int ANGLE_FRAC_BITS = ata_pkg::ANGLE_FRAC_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [ata_pkg::QUOT_W-1:0]       zmag,
	input  ata_pkg::ata_quad_t               quad_in,
	input  logic                             in_valid,
	output logic                             in_ready,
	output logic signed [ANGLE_FRAC_BITS+1:0] poly,
	output ata_pkg::ata_quad_t               quad_out,
	output logic                             out_valid,
	input  logic                             out_ready
);

	localparam int QW     = ata_pkg::QUOT_W;
	localparam int PW     = ata_pkg::P_W;
	localparam int MW     = ata_pkg::M_W;
	localparam int MAG_W  = ANGLE_FRAC_BITS + 1;
	localparam int RND_SH = 44 - ANGLE_FRAC_BITS;
	localparam int OUT_SH = 45 - ANGLE_FRAC_BITS;
	localparam logic [MW-1:0] RND = MW'(1) << RND_SH;

	logic rdy1, rdy2, rdy3, rdy4;
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	logic [QW-1:0]      zmag_s1, zmag_s2;
	logic [QW-1:0]      z2_s1;
	logic [PW-1:0]      p_s2;
	logic [MW-1:0]      m_s3;
	logic signed [MAG_W:0] poly_s4;
	ata_pkg::ata_quad_t quad_s1, quad_s2, quad_s3, quad_s4;

	logic [2*QW-1:0]      sq_nx;
	logic signed [31:0]   n2_prod;
	logic signed [32:0]   p_full;
	logic [MW-1:0]        m_nx;
	logic [MW-1:0]        m_rnd;
	logic [MAG_W-1:0]     mag;

	assign rdy4     = !vld_s4 || out_ready;
	assign rdy3     = !vld_s3 || rdy4;
	assign rdy2     = !vld_s2 || rdy3;
	assign rdy1     = !vld_s1 || rdy2;
	assign in_ready = rdy1;

	// Square of the ratio, back to Q1.15
	assign sq_nx = zmag * zmag;

	// p = N1*2^15 + N2*z2
	always_comb begin
		n2_prod = ata_pkg::COEF_N2 * $signed({1'b0, z2_s1});
		p_full  = $signed({2'b00, ata_pkg::COEF_N1, {ata_pkg::RATIO_FRAC{1'b0}}})
			+ 33'(n2_prod);
	end

	// |z| * p, Q45
	assign m_nx = zmag_s2 * p_s2;

	// Round to nearest on the magnitude
	always_comb begin
		m_rnd = m_s3 + RND;
		mag   = m_rnd[OUT_SH +: MAG_W];
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy1) begin
				vld_s1 <= in_valid;
			end
			if (rdy2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy4) begin
				vld_s4 <= vld_s3;
			end
		end
	end

	// Load payload per stage
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			zmag_s1 <= zmag;
			z2_s1   <= sq_nx[ata_pkg::RATIO_FRAC +: QW];
			quad_s1 <= quad_in;
		end
		if (rdy2 && vld_s1) begin
			zmag_s2 <= zmag_s1;
			p_s2    <= p_full[PW-1:0];
			quad_s2 <= quad_s1;
		end
		if (rdy3 && vld_s2) begin
			m_s3    <= m_nx;
			quad_s3 <= quad_s2;
		end
		if (rdy4 && vld_s3) begin
			poly_s4 <= quad_s3.z_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
			quad_s4 <= quad_s3;
		end
	end

	assign poly      = poly_s4;
	assign quad_out  = quad_s4;
	assign out_valid = vld_s4;

endmodule

>>> sv/ata_back.sv
module ata_back #(
	parameter int ANGLE_FRAC_BITS = ata_pkg::ANGLE_FRAC_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic signed [ANGLE_FRAC_BITS+1:0] poly,
	input  ata_pkg::ata_quad_t                quad,
	input  logic                              in_valid,
	output logic                              in_ready,
	output logic signed [ANGLE_FRAC_BITS+2:0] angle,
	output logic                              out_valid,
	input  logic                              out_ready
);

	localparam int AW = ANGLE_FRAC_BITS + 3;
	localparam logic signed [AW:0] PI_V = (AW+1)'(ata_pkg::pi_fixed(ANGLE_FRAC_BITS));
	localparam logic signed [AW:0] HP_V = (AW+1)'(ata_pkg::half_pi_fixed(ANGLE_FRAC_BITS));

	logic signed [AW:0]   poly_x;
	logic signed [AW:0]   r;
	logic signed [AW:0]   r_sat;
	logic                 y_pos;
	logic                 vld_s1;
	logic signed [AW-1:0] angle_s1;

	// Place the polynomial in its quadrant
	always_comb begin
		poly_x = (AW+1)'(poly);
		y_pos  = !quad.y_neg && !quad.y_zero;
		if (quad.x_zero) begin
			r = y_pos ? HP_V : (quad.y_neg ? -HP_V : '0);
		end else if (!quad.swap) begin
			r = poly_x;
			if (quad.x_neg) begin
				r = r + (quad.y_neg ? -PI_V : PI_V);
			end
		end else begin
			r = (quad.y_neg ? -HP_V : HP_V) - poly_x;
		end
		// Clamp to +/-pi
		if (r > PI_V) begin
			r_sat = PI_V;
		end else if (r < -PI_V) begin
			r_sat = -PI_V;
		end else begin
			r_sat = r;
		end
	end

	assign in_ready = !vld_s1 || out_ready;

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			angle_s1 <= r_sat[AW-1:0];
		end
	end

	assign angle     = angle_s1;
	assign out_valid = vld_s1;

endmodule

>>> sv/fast_atan2_approx.sv
// Four-quadrant arctangent of a signed coordinate pair, polynomial approximation.
// Input channel: x_value, y_value with in_valid / in_ready; an item is taken on a
// clock edge where both are high. Output channel: angle in radians, signed with
// ANGLE_FRAC_BITS fraction bits and clamped to +/-pi, with out_valid / out_ready.
// One result leaves for every item, in order.
// The path has 10 register stages: one for magnitudes and operand select, four of
// the restoring divider (four quotient bits each, sixteen in all), four for the
// polynomial (square, coefficient multiply, ratio multiply, round), and one output
// stage for quadrant offset and clamp.
// Throughput is one item per clock while out_ready is high; the three multiplier
// stages and the divider stages are each fully pipelined.
// Every stage has its own valid bit and loads when it is empty or its successor
// loads, so a stalled receiver fills the bubbles first and then holds each item
// in place; in_ready falls only when all stages hold items.
// Asynchronous reset (arst_n low) clears every valid bit; no item is in flight
// after reset.
module fast_atan2_approx #(
	parameter int COORD_WIDTH     = ata_pkg::COORD_WIDTH_DEF,
	parameter int ANGLE_FRAC_BITS = ata_pkg::ANGLE_FRAC_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic signed [COORD_WIDTH-1:0]     x_value,
	input  logic signed [COORD_WIDTH-1:0]     y_value,
	input  logic                              in_valid,
	output logic                              in_ready,
	output logic signed [ANGLE_FRAC_BITS+2:0] angle,
	output logic                              out_valid,
	input  logic                              out_ready
);

	logic [COORD_WIDTH-1:0]           num, den;
	ata_pkg::ata_quad_t               quad_f, quad_d, quad_p;
	logic                             vld_f, rdy_f, vld_d, rdy_d, vld_p, rdy_p;
	logic [ata_pkg::QUOT_W-1:0]       zmag;
	logic signed [ANGLE_FRAC_BITS+1:0] poly;

	// Magnitudes and operand select
	ata_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.x_value   (x_value),
		.y_value   (y_value),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.num       (num),
		.den       (den),
		.quad      (quad_f),
		.out_valid (vld_f),
		.out_ready (rdy_f)
	);

	// Ratio in Q1.15
	ata_div #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.num       (num),
		.den       (den),
		.quad_in   (quad_f),
		.in_valid  (vld_f),
		.in_ready  (rdy_f),
		.zmag      (zmag),
		.quad_out  (quad_d),
		.out_valid (vld_d),
		.out_ready (rdy_d)
	);

	// Odd polynomial of the ratio
	ata_poly #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_poly (
		.clk       (clk),
		.arst_n    (arst_n),
		.zmag      (zmag),
		.quad_in   (quad_d),
		.in_valid  (vld_d),
		.in_ready  (rdy_d),
		.poly      (poly),
		.quad_out  (quad_p),
		.out_valid (vld_p),
		.out_ready (rdy_p)
	);

	// Quadrant offset, clamp and output register
	ata_back #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.poly      (poly),
		.quad      (quad_p),
		.in_valid  (vld_p),
		.in_ready  (rdy_p),
		.angle     (angle),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

endmodule

>>> verif/tb_fast_atan2_approx.sv
`timescale 1ns / 100ps

module tb_fast_atan2_approx;

	localparam int COORD_W     = ata_pkg::COORD_WIDTH_DEF;
	localparam int FRAC        = ata_pkg::ANGLE_FRAC_DEF;
	localparam int ANGLE_W     = FRAC + 3;
	localparam int Z_FRAC      = 15;
	localparam int RANDOM_N    = 1050;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE      = 24;

	// Polynomial coefficients in Q0.15 and pi with 61 fraction bits
	localparam longint N1_Q15 = 31863;
	localparam longint N2_Q15 = -6290;
	localparam logic [63:0] PI_Q61_BITS = 64'h6487ED5110B4611A;
	localparam longint PI_ANGLE   = longint'(((PI_Q61_BITS >> (60 - FRAC)) + 64'd1) >> 1);
	localparam longint HALF_PI_ANG = longint'(((PI_Q61_BITS >> (61 - FRAC)) + 64'd1) >> 1);

	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} coord_pair_t;

	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [ANGLE_W-1:0] angle;
	} angle_due_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic signed [COORD_W-1:0]  x_value = '0;
	logic signed [COORD_W-1:0]  y_value = '0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic signed [ANGLE_W-1:0]  angle;
	logic                       out_valid;
	logic                       out_ready = 1'b0;

	coord_pair_t coords_waiting[$];
	angle_due_t  angles_due[$];
	coord_pair_t next_pair;
	angle_due_t  due_head;
	int          items_sent = 0;
	int          items_seen = 0;
	int          gap_left = 0;
	int          stall_left = 0;
	int          quiet_cycles = 0;
	int          mismatches = 0;

	fast_atan2_approx uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.x_value   (x_value),
		.y_value   (y_value),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.angle     (angle),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Odd polynomial of num/den in output units; caller keeps |num| <= |den|, den != 0
	function automatic longint poly_angle(longint num, longint den);
		longint an, ad, zmag, z2, p, a;
		logic   neg;
		an   = (num < 0) ? -num : num;
		ad   = (den < 0) ? -den : den;
		neg  = (num < 0) != (den < 0);
		zmag = (an << Z_FRAC) / ad;
		z2   = (zmag * zmag) >> Z_FRAC;
		p    = N1_Q15 * (longint'(1) << Z_FRAC) + N2_Q15 * z2;
		a    = (zmag * p + (longint'(1) << (44 - FRAC))) >> (45 - FRAC);
		return (neg && zmag != 0) ? -a : a;
	endfunction

	// Four-quadrant angle with quadrant offsets and clamp to +/-pi
	function automatic logic signed [ANGLE_W-1:0] atan2_fixed(
		logic signed [COORD_W-1:0] xv,
		logic signed [COORD_W-1:0] yv
	);
		longint x, y, ax, ay, r;
		x  = xv;
		y  = yv;
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		if (x == 0) begin
			r = (y > 0) ? HALF_PI_ANG : ((y < 0) ? -HALF_PI_ANG : 0);
		end else if (ax >= ay) begin
			r = poly_angle(y, x);
			if (x < 0)
				r += (y < 0) ? -PI_ANGLE : PI_ANGLE;
		end else begin
			r = ((y < 0) ? -HALF_PI_ANG : HALF_PI_ANG) - poly_angle(x, y);
		end
		if (r > PI_ANGLE)
			r = PI_ANGLE;
		if (r < -PI_ANGLE)
			r = -PI_ANGLE;
		return ANGLE_W'(r);
	endfunction

	// Idle length: one phase in four runs at full rate, otherwise mostly no gap or a short one
	function automatic int pick_idle(int count);
		int roll;
		if ((count / 150) % 4 == 1)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	task automatic add_pair(int xv, int yv);
		coord_pair_t pr;
		pr.x = COORD_W'(xv);
		pr.y = COORD_W'(yv);
		coords_waiting.push_back(pr);
	endtask

	// Drive items from the waiting queue, predict each accepted item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready) begin
				angles_due.push_back('{x_value, y_value, atan2_fixed(x_value, y_value)});
				items_sent <= items_sent + 1;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (coords_waiting.size() > 0) begin
					next_pair = coords_waiting.pop_front();
					x_value <= next_pair.x;
					y_value <= next_pair.y;
					in_valid <= 1'b1;
					gap_left <= pick_idle(items_sent);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Compare each result with the oldest prediction and stall the output at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				items_seen <= items_seen + 1;
				if (angles_due.size() == 0) begin
					$display("%0t: unexpected result angle=%0d", $time, angle);
					mismatches++;
				end else begin
					due_head = angles_due.pop_front();
					if (angle !== due_head.angle) begin
						$display("%0t: angle mismatch x=%0d y=%0d expected %0d actual %0d",
							$time, due_head.x, due_head.y, due_head.angle, angle);
						mismatches++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				stall_left <= pick_idle(items_seen);
			end
		end
	end

	// Count cycles with work outstanding but no item moving
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else if (in_valid || coords_waiting.size() > 0 || angles_due.size() > 0)
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("fast_atan2_approx regression: fail");
		$finish;
	end

	initial begin
		int kind, a, b;

		// Axes, zero, corners, diagonals and steep angles
		add_pair(0, 0);
		add_pair(0, 1);
		add_pair(0, -1);
		add_pair(0, 32767);
		add_pair(0, -32768);
		add_pair(1, 0);
		add_pair(-1, 0);
		add_pair(32767, 0);
		add_pair(-32768, 0);
		add_pair(32767, 32767);
		add_pair(-32768, -32768);
		add_pair(-32768, 32767);
		add_pair(32767, -32768);
		add_pair(-32768, 1);
		add_pair(-32768, -1);
		add_pair(-1, 1);
		add_pair(-1, -1);
		add_pair(1, 2);
		add_pair(-1, 2);
		add_pair(1, -2);
		add_pair(-1, -2);
		add_pair(5, -32768);
		add_pair(-32767, -32768);
		add_pair(-32767, 32767);
		add_pair(100, 99);

		// Random pairs, weighted toward ratios near the branch boundaries
		repeat (RANDOM_N) begin
			kind = $urandom_range(0, 99);
			a = $urandom_range(0, 65535) - 32768;
			b = $urandom_range(0, 65535) - 32768;
			if (kind < 30) begin
				add_pair(a, b);
			end else if (kind < 45) begin
				add_pair(int'($urandom_range(0, 16)) - 8, int'($urandom_range(0, 16)) - 8);
			end else if (kind < 55) begin
				b = ($urandom_range(0, 1) != 0) ? -a : a;
				add_pair(a, b + int'($urandom_range(0, 2)) - 1);
			end else if (kind < 65) begin
				if ($urandom_range(0, 1) != 0)
					add_pair(0, b);
				else
					add_pair(a, 0);
			end else if (kind < 75) begin
				case ($urandom_range(0, 6))
					0: a = -32768;
					1: a = -32767;
					2: a = -1;
					3: a = 0;
					4: a = 1;
					5: a = 32766;
					default: a = 32767;
				endcase
				if ($urandom_range(0, 1) != 0)
					add_pair(a, b);
				else
					add_pair(b, a);
			end else if (kind < 90) begin
				b = a + int'($urandom_range(0, 64)) - 32;
				if ($urandom_range(0, 1) != 0)
					b = -b;
				add_pair(a, b);
			end else begin
				b = int'($urandom_range(0, 64)) - 32;
				if ($urandom_range(0, 1) != 0)
					add_pair(a, b);
				else
					add_pair(b, a);
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Hold until all items are sent and every prediction is matched
		while (coords_waiting.size() > 0 || in_valid || angles_due.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (mismatches == 0)
			$display("fast_atan2_approx regression: pass");
		else
			$display("fast_atan2_approx regression: fail");
		$finish;
	end

endmodule
